@@ rtl/wsctl_pkg.sv @@
// Package for the WebSocket control frame handler.
// Holds the opcode, kind and UTF-8 class codes and the shared structs.
// No dependencies.
package wsctl_pkg;

   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   localparam logic [1:0] KIND_CLOSE   = 2'd0;
   localparam logic [1:0] KIND_PING    = 2'd1;
   localparam logic [1:0] KIND_PONG    = 2'd2;
   localparam logic [1:0] KIND_INVALID = 2'd3;

   localparam logic [6:0] MAX_LEN = 7'd125;

   localparam logic [7:0] FAIL_CODE_HI = 8'h03;
   localparam logic [7:0] FAIL_CODE_LO = 8'hEA;

   localparam logic [15:0] CODE_STD_LO  = 16'd1000;
   localparam logic [15:0] CODE_STD_HI  = 16'd1003;
   localparam logic [15:0] CODE_EXT_LO  = 16'd1007;
   localparam logic [15:0] CODE_EXT_HI  = 16'd1011;
   localparam logic [15:0] CODE_APP_LO  = 16'd3000;
   localparam logic [15:0] CODE_APP_HI  = 16'd4999;

   localparam logic [2:0] LEAD_NONE = 3'd0;
   localparam logic [2:0] LEAD_E0   = 3'd1;
   localparam logic [2:0] LEAD_ED   = 3'd2;
   localparam logic [2:0] LEAD_F0   = 3'd3;
   localparam logic [2:0] LEAD_F4   = 3'd4;

   typedef struct packed {
      logic [1:0] pending;
      logic [2:0] lead_class;
      logic       bad;
   } utf8_state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [6:0] out_pos;
      logic [1:0] frame_kind;
      logic       utf8_error;
      logic       last_of_frame;
   } result_type;

endpackage

@@ rtl/websocket_control_frame_handler_core.sv @@
// WebSocket control frame handler: unmasks close and ping payloads,
// checks the close code and reason text, and rewrites ping as pong.
// Depends on wsctl_pkg and wsctl_utf8.
// The first result of a word is registered and on rsp_* in the cycle after it is accepted.
// Throughput: one word per cycle while rsp_tready is high; a word with two results (frame
// start, second close code byte) holds req_tready low while the two-entry result buffer
// drains. The rate is set by the single output port of that buffer.
// Reset (synchronous, active high) empties the buffer and clears the frame state.
module websocket_control_frame_handler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // head_first[7:0], head_second[15:8], payload_len[22:16], mask_key[54:23],
   // payload_byte[62:55], zero[63]
   input  logic [63:0] req_tdata,
   // func[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_byte[7:0], out_pos[14:8], zero[15]
   output logic [15:0] rsp_tdata,
   // frame_kind[1:0], utf8_error[2]
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   logic [7:0]  head_first;
   logic [7:0]  head_second;
   logic [6:0]  payload_len;
   logic [31:0] mask_key;
   logic [7:0]  payload_byte;

   assign head_first   = req_tdata[7:0];
   assign head_second  = req_tdata[15:8];
   assign payload_len  = req_tdata[22:16];
   assign mask_key     = req_tdata[54:23];
   assign payload_byte = req_tdata[62:55];

   logic [1:0]  kind_ff, kind_in;
   logic [31:0] key_ff, key_in;
   logic [6:0]  left_ff, left_in;
   logic [6:0]  index_ff, index_in;
   logic [7:0]  held_ff, held_in;
   wsctl_pkg::utf8_state_type utf8_ff, utf8_in, utf8_step;

   wsctl_pkg::result_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   wsctl_pkg::result_type res0, res1;
   logic [1:0] count_ff, count_in;
   logic [1:0] res_count;

   logic accept, pop;
   logic [6:0] len_sat;
   logic [1:0] start_kind;
   logic [7:0] key_byte, plain;
   logic [6:0] pos;
   logic       last;
   logic [15:0] close_code;
   logic        code_ok;

   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = {1'b0, slot0_ff.out_pos, slot0_ff.out_byte};
   assign rsp_tuser  = {slot0_ff.utf8_error, slot0_ff.frame_kind};
   assign rsp_tlast  = slot0_ff.last_of_frame;

   wsctl_utf8 u_utf8 (
      .state_cur  (utf8_ff),
      .char_byte  (plain),
      .state_next (utf8_step)
   );

   always_comb begin
      len_sat = (payload_len > wsctl_pkg::MAX_LEN) ? wsctl_pkg::MAX_LEN : payload_len;
      unique case (head_first[3:0])
         wsctl_pkg::OP_CLOSE: start_kind = wsctl_pkg::KIND_CLOSE;
         wsctl_pkg::OP_PING:  start_kind = wsctl_pkg::KIND_PING;
         wsctl_pkg::OP_PONG:  start_kind = wsctl_pkg::KIND_PONG;
         default:             start_kind = wsctl_pkg::KIND_INVALID;
      endcase
      case (index_ff[1:0])
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
      plain      = payload_byte ^ key_byte;
      pos        = index_ff + 7'd2;
      last       = (left_ff == 7'd1);
      close_code = {held_ff, plain};
      code_ok    = (close_code >= wsctl_pkg::CODE_STD_LO && close_code <= wsctl_pkg::CODE_STD_HI)
                || (close_code >= wsctl_pkg::CODE_EXT_LO && close_code <= wsctl_pkg::CODE_EXT_HI)
                || (close_code >= wsctl_pkg::CODE_APP_LO && close_code <= wsctl_pkg::CODE_APP_HI);
   end

   always_comb begin
      kind_in   = kind_ff;
      key_in    = key_ff;
      left_in   = left_ff;
      index_in  = index_ff;
      held_in   = held_ff;
      utf8_in   = utf8_ff;
      res_count = 2'd0;
      res0      = '{out_byte: payload_byte, out_pos: pos, frame_kind: kind_ff,
                    utf8_error: 1'b0, last_of_frame: last};
      res1      = res0;
      if (req_tuser == 1'b0) begin
         kind_in  = start_kind;
         key_in   = mask_key;
         left_in  = len_sat;
         index_in = 7'd0;
         held_in  = 8'd0;
         utf8_in  = '0;
         res_count = 2'd2;
         res0.out_byte      = head_first;
         res0.out_pos       = 7'd0;
         res0.frame_kind    = start_kind;
         res0.last_of_frame = 1'b0;
         if (start_kind == wsctl_pkg::KIND_PING) begin
            res0.out_byte = {head_first[7:4], wsctl_pkg::OP_PONG};
         end
         res1 = res0;
         res1.out_byte      = head_second;
         res1.out_pos       = 7'd1;
         res1.last_of_frame = (len_sat == 7'd0);
         if (start_kind == wsctl_pkg::KIND_CLOSE || start_kind == wsctl_pkg::KIND_PING) begin
            res1.out_byte = {1'b0, head_second[6:0]};
         end
      end else if (left_ff != 7'd0) begin
         index_in = index_ff + 7'd1;
         left_in  = left_ff - 7'd1;
         res_count = 2'd1;
         if (kind_ff == wsctl_pkg::KIND_PING) begin
            res0.out_byte = plain;
         end else if (kind_ff == wsctl_pkg::KIND_CLOSE) begin
            res0.out_byte = plain;
            if (index_ff == 7'd0) begin
               if (last) begin
                  res0.out_byte = wsctl_pkg::FAIL_CODE_HI;
               end else begin
                  held_in   = plain;
                  res_count = 2'd0;
               end
            end else if (index_ff == 7'd1) begin
               res_count = 2'd2;
               res0.out_byte      = code_ok ? held_ff : wsctl_pkg::FAIL_CODE_HI;
               res0.out_pos       = 7'd2;
               res0.last_of_frame = 1'b0;
               res1 = res0;
               res1.out_byte      = code_ok ? plain : wsctl_pkg::FAIL_CODE_LO;
               res1.out_pos       = 7'd3;
               res1.last_of_frame = last;
            end else begin
               utf8_in = utf8_step;
               res0.utf8_error = last && (utf8_step.bad || utf8_step.pending != 2'd0);
            end
         end
      end
   end

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (accept) begin
         slot0_in = res0;
         slot1_in = res1;
         count_in = res_count;
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= wsctl_pkg::KIND_INVALID;
         key_ff   <= '0;
         left_ff  <= '0;
         index_ff <= '0;
         held_ff  <= '0;
         utf8_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (accept) begin
            kind_ff  <= kind_in;
            key_ff   <= key_in;
            left_ff  <= left_in;
            index_ff <= index_in;
            held_ff  <= held_in;
            utf8_ff  <= utf8_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

@@ rtl/wsctl_utf8.sv @@
// Strict UTF-8 decoder step: next checker state for one reason text byte.
// Depends on wsctl_pkg for the state struct and lead byte class codes.
module wsctl_utf8 (
   input  wsctl_pkg::utf8_state_type state_cur,
   input  logic [7:0]                char_byte,
   output wsctl_pkg::utf8_state_type state_next
);

   logic [7:0] range_lo;
   logic [7:0] range_hi;

   always_comb begin
      range_lo = 8'h80;
      range_hi = 8'hBF;
      case (state_cur.lead_class)
         wsctl_pkg::LEAD_E0: range_lo = 8'hA0;
         wsctl_pkg::LEAD_ED: range_hi = 8'h9F;
         wsctl_pkg::LEAD_F0: range_lo = 8'h90;
         wsctl_pkg::LEAD_F4: range_hi = 8'h8F;
         default: ;
      endcase
   end

   always_comb begin
      state_next            = state_cur;
      state_next.lead_class = wsctl_pkg::LEAD_NONE;
      if (state_cur.pending != 2'd0) begin
         if (char_byte < range_lo || char_byte > range_hi) begin
            state_next.bad     = 1'b1;
            state_next.pending = 2'd0;
         end else begin
            state_next.pending = state_cur.pending - 2'd1;
         end
      end else if (char_byte <= 8'h7F) begin
         state_next.pending = 2'd0;
      end else if (char_byte >= 8'hC2 && char_byte <= 8'hDF) begin
         state_next.pending = 2'd1;
      end else if (char_byte >= 8'hE0 && char_byte <= 8'hEF) begin
         state_next.pending = 2'd2;
         if (char_byte == 8'hE0) begin
            state_next.lead_class = wsctl_pkg::LEAD_E0;
         end else if (char_byte == 8'hED) begin
            state_next.lead_class = wsctl_pkg::LEAD_ED;
         end
      end else if (char_byte >= 8'hF0 && char_byte <= 8'hF4) begin
         state_next.pending = 2'd3;
         if (char_byte == 8'hF0) begin
            state_next.lead_class = wsctl_pkg::LEAD_F0;
         end else if (char_byte == 8'hF4) begin
            state_next.lead_class = wsctl_pkg::LEAD_F4;
         end
      end else begin
         state_next.bad = 1'b1;
      end
   end

endmodule

@@ sim/tb_websocket_control_frame_handler_core.sv @@
// Self-checking testbench for websocket_control_frame_handler_core.
// Drives directed and random control frames and predicts every output word.
// Depends on wsctl_pkg and the RTL of the handler.
module tb_websocket_control_frame_handler_core;
   timeunit 1ns;
   timeprecision 1ps;

   class reply_scoreboard;
      wsctl_pkg::result_type replies[$];
      int errors;
      int checked;
      logic [1:0] kind;
      logic [31:0] key;
      logic [6:0] left;
      logic [6:0] index;
      logic [7:0] held_hi;
      logic [1:0] u_pending;
      logic [2:0] u_lead;
      logic u_bad;

      function new();
         errors = 0;
         checked = 0;
         kind = wsctl_pkg::KIND_INVALID;
         key = '0;
         left = '0;
         index = '0;
         held_hi = '0;
         u_pending = '0;
         u_lead = wsctl_pkg::LEAD_NONE;
         u_bad = 1'b0;
      endfunction

      function void push_reply(logic [7:0] b, logic [6:0] p, logic err, logic last);
         wsctl_pkg::result_type r;
         r.out_byte = b;
         r.out_pos = p;
         r.frame_kind = kind;
         r.utf8_error = err;
         r.last_of_frame = last;
         replies.push_back(r);
      endfunction

      function bit code_valid(logic [15:0] c);
         return (c >= wsctl_pkg::CODE_STD_LO && c <= wsctl_pkg::CODE_STD_HI) ||
                (c >= wsctl_pkg::CODE_EXT_LO && c <= wsctl_pkg::CODE_EXT_HI) ||
                (c >= wsctl_pkg::CODE_APP_LO && c <= wsctl_pkg::CODE_APP_HI);
      endfunction

      function void feed_utf8(logic [7:0] c);
         logic [7:0] lo;
         logic [7:0] hi;
         lo = 8'h80;
         hi = 8'hBF;
         if (u_pending != 0) begin
            case (u_lead)
               wsctl_pkg::LEAD_E0: lo = 8'hA0;
               wsctl_pkg::LEAD_ED: hi = 8'h9F;
               wsctl_pkg::LEAD_F0: lo = 8'h90;
               wsctl_pkg::LEAD_F4: hi = 8'h8F;
               default: ;
            endcase
            if (c < lo || c > hi) begin
               u_bad = 1'b1;
               u_pending = 2'd0;
            end else begin
               u_pending = u_pending - 2'd1;
            end
            u_lead = wsctl_pkg::LEAD_NONE;
         end else begin
            u_lead = wsctl_pkg::LEAD_NONE;
            if (c <= 8'h7F) begin
            end else if (c >= 8'hC2 && c <= 8'hDF) begin
               u_pending = 2'd1;
            end else if (c >= 8'hE0 && c <= 8'hEF) begin
               u_pending = 2'd2;
               if (c == 8'hE0) u_lead = wsctl_pkg::LEAD_E0;
               else if (c == 8'hED) u_lead = wsctl_pkg::LEAD_ED;
            end else if (c >= 8'hF0 && c <= 8'hF4) begin
               u_pending = 2'd3;
               if (c == 8'hF0) u_lead = wsctl_pkg::LEAD_F0;
               else if (c == 8'hF4) u_lead = wsctl_pkg::LEAD_F4;
            end else begin
               u_bad = 1'b1;
            end
         end
      endfunction

      function void note_word(bit func, logic [63:0] d);
         logic [7:0] b0;
         logic [7:0] b1;
         logic [6:0] len;
         logic [7:0] raw;
         logic [7:0] plain;
         logic [6:0] idx;
         logic [6:0] pos;
         logic last;
         logic [15:0] code;
         b0 = d[7:0];
         b1 = d[15:8];
         len = d[22:16];
         raw = d[62:55];
         if (!func) begin
            if (len > wsctl_pkg::MAX_LEN) len = wsctl_pkg::MAX_LEN;
            case (b0[3:0])
               wsctl_pkg::OP_CLOSE: kind = wsctl_pkg::KIND_CLOSE;
               wsctl_pkg::OP_PING:  kind = wsctl_pkg::KIND_PING;
               wsctl_pkg::OP_PONG:  kind = wsctl_pkg::KIND_PONG;
               default:             kind = wsctl_pkg::KIND_INVALID;
            endcase
            key = d[54:23];
            left = len;
            index = '0;
            held_hi = '0;
            u_pending = '0;
            u_lead = wsctl_pkg::LEAD_NONE;
            u_bad = 1'b0;
            if (kind == wsctl_pkg::KIND_PING) b0 = {b0[7:4], wsctl_pkg::OP_PONG};
            if (kind == wsctl_pkg::KIND_CLOSE || kind == wsctl_pkg::KIND_PING) b1[7] = 1'b0;
            push_reply(b0, 7'd0, 1'b0, 1'b0);
            push_reply(b1, 7'd1, 1'b0, len == 0);
         end else if (left != 0) begin
            idx = index;
            plain = raw ^ key[8 * (3 - idx[1:0]) +: 8];
            pos = idx + 7'd2;
            index = index + 7'd1;
            left = left - 7'd1;
            last = (left == 0);
            if (kind == wsctl_pkg::KIND_PONG || kind == wsctl_pkg::KIND_INVALID) begin
               push_reply(raw, pos, 1'b0, last);
            end else if (kind == wsctl_pkg::KIND_PING) begin
               push_reply(plain, pos, 1'b0, last);
            end else if (idx == 0) begin
               if (last) push_reply(wsctl_pkg::FAIL_CODE_HI, 7'd2, 1'b0, 1'b1);
               else held_hi = plain;
            end else if (idx == 1) begin
               code = {held_hi, plain};
               if (code_valid(code)) begin
                  push_reply(held_hi, 7'd2, 1'b0, 1'b0);
                  push_reply(plain, 7'd3, 1'b0, last);
               end else begin
                  push_reply(wsctl_pkg::FAIL_CODE_HI, 7'd2, 1'b0, 1'b0);
                  push_reply(wsctl_pkg::FAIL_CODE_LO, 7'd3, 1'b0, last);
               end
            end else begin
               feed_utf8(plain);
               push_reply(plain, pos, last && (u_bad || u_pending != 0), last);
            end
         end
      endfunction

      function void check_word(logic [15:0] td, logic [2:0] tu, logic tl);
         wsctl_pkg::result_type r;
         bit bad;
         bad = 1'b0;
         if (replies.size() == 0) begin
            $display("%0t: unexpected result word, actual byte %02h pos %0d",
                     $time, td[7:0], td[14:8]);
            errors++;
         end else begin
            r = replies.pop_front();
            checked++;
            if (r.out_byte !== td[7:0]) begin
               $display("%0t: out_byte expected %02h actual %02h", $time, r.out_byte, td[7:0]);
               bad = 1'b1;
            end
            if (r.out_pos !== td[14:8]) begin
               $display("%0t: out_pos expected %0d actual %0d", $time, r.out_pos, td[14:8]);
               bad = 1'b1;
            end
            if (r.frame_kind !== tu[1:0]) begin
               $display("%0t: frame_kind expected %0d actual %0d",
                        $time, r.frame_kind, tu[1:0]);
               bad = 1'b1;
            end
            if (r.utf8_error !== tu[2]) begin
               $display("%0t: utf8_error expected %0b actual %0b", $time, r.utf8_error, tu[2]);
               bad = 1'b1;
            end
            if (r.last_of_frame !== tl) begin
               $display("%0t: last_of_frame expected %0b actual %0b",
                        $time, r.last_of_frame, tl);
               bad = 1'b1;
            end
            if (bad) errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   reply_scoreboard sb = new();

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int hold_taken = 0;
   int hold_left = 0;
   int frame_words = 0;
   int stray_words = 0;
   logic [7:0] frame_body[$];

   websocket_control_frame_handler_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // A long hold-off is counted here once the stimulus asks for it.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_taken != hold_requests) begin
         hold_taken <= hold_requests;
         hold_left <= 300;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   task automatic send_word(input bit func, input logic [63:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_word(func, d);
      @(negedge clock);
   endtask

   task automatic send_start(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [6:0] len, input logic [31:0] key);
      send_word(1'b0, {1'b0, 8'($urandom), key, len, b1, b0});
   endtask

   task automatic send_payload(input logic [7:0] raw);
      send_word(1'b1, {1'b0, raw, 32'($urandom), 7'($urandom), 8'($urandom), 8'($urandom)});
   endtask

   task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1, input logic [6:0] len,
                             input logic [31:0] key, input int nsend);
      send_start(b0, b1, len, key);
      frame_words++;
      for (int i = 0; i < nsend; i++) begin
         send_payload(frame_body[i] ^ key[8 * (3 - (i % 4)) +: 8]);
         frame_words++;
      end
   endtask

   task automatic go_quiet();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.replies.size() != 0);
   endtask

   // Appends one character of reason text, mostly well-formed UTF-8.
   task automatic add_char();
      int pick;
      logic [7:0] lead;
      pick = $urandom_range(9);
      if (pick < 4) begin
         frame_body.push_back(8'($urandom_range(0, 8'h7F)));
      end else if (pick == 4) begin
         frame_body.push_back(8'($urandom_range(8'hC2, 8'hDF)));
         frame_body.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (pick == 5) begin
         lead = $urandom_range(1) ? ($urandom_range(1) ? 8'hE0 : 8'hED)
                                  : 8'($urandom_range(8'hE0, 8'hEF));
         frame_body.push_back(lead);
         if (lead == 8'hE0) frame_body.push_back(8'($urandom_range(8'hA0, 8'hBF)));
         else if (lead == 8'hED) frame_body.push_back(8'($urandom_range(8'h80, 8'h9F)));
         else frame_body.push_back(8'($urandom_range(8'h80, 8'hBF)));
         frame_body.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (pick == 6) begin
         lead = $urandom_range(1) ? ($urandom_range(1) ? 8'hF0 : 8'hF4)
                                  : 8'($urandom_range(8'hF0, 8'hF4));
         frame_body.push_back(lead);
         if (lead == 8'hF0) frame_body.push_back(8'($urandom_range(8'h90, 8'hBF)));
         else if (lead == 8'hF4) frame_body.push_back(8'($urandom_range(8'h80, 8'h8F)));
         else frame_body.push_back(8'($urandom_range(8'h80, 8'hBF)));
         frame_body.push_back(8'($urandom_range(8'h80, 8'hBF)));
         frame_body.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (pick == 7) begin
         frame_body.push_back(8'($urandom_range(8'h80, 8'hFF)));
      end else begin
         frame_body.push_back(8'($urandom));
      end
   endtask

   task automatic build_close_body(input int reason_len);
      int pick;
      logic [15:0] code;
      logic [15:0] edge_codes[8];
      edge_codes = '{16'd999, 16'd1004, 16'd1006, 16'd1012, 16'd2999, 16'd5000, 16'd0,
                     16'hFFFF};
      pick = $urandom_range(9);
      if (pick < 2)
         code = 16'($urandom_range(wsctl_pkg::CODE_STD_LO, wsctl_pkg::CODE_STD_HI));
      else if (pick < 4)
         code = 16'($urandom_range(wsctl_pkg::CODE_EXT_LO, wsctl_pkg::CODE_EXT_HI));
      else if (pick < 6)
         code = 16'($urandom_range(wsctl_pkg::CODE_APP_LO, wsctl_pkg::CODE_APP_HI));
      else if (pick < 8) code = edge_codes[$urandom_range(7)];
      else code = 16'($urandom);
      frame_body.push_back(code[15:8]);
      frame_body.push_back(code[7:0]);
      while (frame_body.size() < reason_len + 2) add_char();
   endtask

   task automatic random_frame();
      int pick;
      int nsend;
      bit big_frame;
      logic [3:0] op;
      logic [6:0] len;
      logic [31:0] key;
      frame_body.delete();
      if ($urandom_range(99) < 6) begin
         send_payload(8'($urandom));
         stray_words++;
         return;
      end
      pick = $urandom_range(99);
      if (pick < 40) op = wsctl_pkg::OP_CLOSE;
      else if (pick < 65) op = wsctl_pkg::OP_PING;
      else if (pick < 80) op = wsctl_pkg::OP_PONG;
      else op = 4'($urandom);
      big_frame = ($urandom_range(99) < 4);
      if (op == wsctl_pkg::OP_CLOSE) begin
         pick = $urandom_range(99);
         if (pick >= 16 || big_frame) begin
            build_close_body(big_frame ? 123 : ($urandom_range(15) == 0 ? $urandom_range(9, 40)
                                                                        : $urandom_range(0, 8)));
         end else if (pick >= 8) begin
            frame_body.push_back(8'($urandom));
         end
      end else begin
         repeat (big_frame ? 125 : $urandom_range(0, 12)) frame_body.push_back(8'($urandom));
      end
      while (frame_body.size() > 125) void'(frame_body.pop_back());
      len = big_frame ? 7'($urandom_range(125, 127)) : 7'(frame_body.size());
      nsend = frame_body.size();
      if (nsend > 0 && $urandom_range(99) < 8) nsend = $urandom_range(0, nsend - 1);
      pick = $urandom_range(99);
      if (pick < 8) key = '0;
      else if (pick < 12) key = '1;
      else key = $urandom;
      send_frame({4'($urandom), op}, 8'($urandom), len, key, nsend);
      if (nsend == frame_body.size() && $urandom_range(99) < 4) begin
         send_payload(8'($urandom));
         stray_words++;
      end
   endtask

   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int target;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      frame_body.delete();
      send_frame(8'h88, 8'h80, 7'd0, 32'h1234ABCD, 0);
      frame_body = '{8'h03, 8'hE8, 8'h41, 8'hC3, 8'hA9};
      send_frame(8'h88, 8'h85, 7'd5, 32'hFFFFFFFF, 5);
      frame_body = '{8'h12};
      send_frame(8'h88, 8'h81, 7'd1, 32'hA5A55A5A, 1);
      frame_body = '{8'h00, 8'h00, 8'hFF};
      send_frame(8'h08, 8'h03, 7'd3, 32'h00000000, 3);
      frame_body = '{8'h00, 8'hFF};
      send_frame(8'hF9, 8'hFF, 7'd2, 32'hFFFFFFFF, 2);
      frame_body = '{8'h77};
      send_frame(8'h09, 8'h7F, 7'd127, 32'h0F0F0F0F, 1);
      frame_body = '{8'h5A};
      send_frame(8'h8A, 8'h81, 7'd1, 32'h12345678, 1);
      frame_body.delete();
      send_frame(8'h00, 8'h00, 7'd0, 32'h87654321, 0);
      send_payload(8'hC3);
      stray_words++;
      go_quiet();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 80 : (phase == 3) ? 13 : 0;
         recv_stall_pct = (phase == 2) ? 80 : (phase == 3) ? 13 : 0;
         target = frame_words + 375;
         while (frame_words < target) begin
            if (phase == 0 && hold_requests == 0 && frame_words > target - 200)
               hold_requests = 1;
            random_frame();
         end
         go_quiet();
      end

      repeat (16) @(negedge clock);
      $display("Sent %0d frame words and %0d stray bytes through four flow-control phases,",
               frame_words, stray_words);
      $display("with one long receiver hold-off; %0d result words were checked.", sb.checked);
      if (sb.errors == 0 && sb.replies.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
